[design/sasp_pkg.sv]
package sasp_pkg;

    // Script store geometry and walk bound
    localparam int SCRIPT_DEPTH = 64;
    localparam int POS_W        = $clog2(SCRIPT_DEPTH);
    localparam int MAX_STEPS    = 512;
    localparam int STEP_W       = $clog2(MAX_STEPS + 1);

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 6;
    localparam int DUR_W   = 16;
    localparam int CODE_W  = 16;
    localparam int SPEED_W = 16;
    localparam int START_W = 6;
    localparam int ENTRY_W = DUR_W + CODE_W;
    localparam int TIMER_W = 24;
    localparam int FRAC_W  = 8;
    localparam int SUM_W   = DUR_W + SPEED_W;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

    // Control entry codes
    localparam logic [CODE_W-1:0] CODE_HOLD    = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_RELEASE = 16'h0001;
    localparam logic [CODE_W-1:0] CODE_LOOP    = 16'hFFFF;

    // Normal speed in 8.8 fixed point
    localparam logic [SPEED_W-1:0] ONE_SPEED = 16'h0100;

    // Configuration register indexes
    localparam logic CFG_SPEED = 1'b0;
    localparam logic CFG_START = 1'b1;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [START_W-1:0] start_position;
    } cfg_t;

    // Script store access from the walker
    typedef struct packed {
        logic               we;
        logic [POS_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [POS_W-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        logic              running;
        logic [CODE_W-1:0] frame_number;
        logic              frame_changed;
        logic              released;
        logic              step_overrun;
    } result_t;

endpackage

[design/sasp_script_ram.sv]
module sasp_script_ram
    import sasp_pkg::*;
(
    input  logic               aclk,
    input  mem_req_t           req,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [SCRIPT_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/sasp_walker.sv]
module sasp_walker
    import sasp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    // incoming transaction
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  in_func,
    input  logic [INDEX_W-1:0] in_index,
    input  logic [DUR_W-1:0]   in_duration,
    input  logic [CODE_W-1:0]  in_code,
    // script store
    output mem_req_t           mem_req,
    input  logic [ENTRY_W-1:0] mem_rdata,
    // result handoff
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_ACCUM = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [CODE_W-1:0]  frame_reg, frame_next;
    logic               active_reg, active_next;
    logic               released_reg, released_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic               run_reg, run_next;
    logic               changed_reg, changed_next;
    logic               overrun_reg, overrun_next;
    // payload registers
    logic [SPEED_W-1:0] rate_reg, rate_next;
    logic [SUM_W-1:0]   prod_reg, prod_next;

    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   start_pos;
    logic [TIMER_W-1:0] timer_dec;
    logic [DUR_W-1:0]   ent_dur;
    logic [CODE_W-1:0]  ent_code;
    logic [SUM_W-1:0]   sum;
    logic               accept;

    assign pos_inc   = (32'(pos_reg) + 1 >= SCRIPT_DEPTH) ? '0 : pos_reg + 1'b1;
    assign start_pos = POS_W'(32'(cfg.start_position) % SCRIPT_DEPTH);
    assign timer_dec = timer_reg - 1'b1;
    assign ent_dur   = mem_rdata[ENTRY_W-1:CODE_W];
    assign ent_code  = mem_rdata[CODE_W-1:0];
    assign sum       = SUM_W'(frac_reg) + prod_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_DONE);

    assign res.running       = run_reg;
    assign res.frame_number  = frame_reg;
    assign res.frame_changed = changed_reg;
    assign res.released      = released_reg;
    assign res.step_overrun  = overrun_reg;

    // Walk sequencer: one store read per entry, multiply, then accumulate
    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        timer_next    = timer_reg;
        frac_next     = frac_reg;
        frame_next    = frame_reg;
        active_next   = active_reg;
        released_next = released_reg;
        steps_next    = steps_reg;
        run_next      = run_reg;
        changed_next  = changed_reg;
        overrun_next  = overrun_reg;
        rate_next     = rate_reg;
        prod_next     = prod_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = POS_W'(in_index);
        mem_req.wdata = {in_duration, in_code};
        mem_req.re    = 1'b0;
        mem_req.raddr = pos_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    steps_next   = '0;
                    changed_next = 1'b0;
                    overrun_next = 1'b0;
                    run_next     = active_reg;
                    state_next   = ST_DONE;
                    unique case (in_func)
                        FUNC_TICK: begin
                            if (active_reg && cfg.speed != '0) begin
                                rate_next = cfg.speed;
                                if (timer_reg != '0) begin
                                    timer_next = timer_dec;
                                    if (timer_dec == '0) begin
                                        pos_next   = pos_inc;
                                        state_next = ST_READ;
                                    end
                                end else begin
                                    state_next = ST_READ;
                                end
                            end
                        end
                        FUNC_WRITE: begin
                            mem_req.we = (32'(in_index) < SCRIPT_DEPTH);
                        end
                        FUNC_RESTART: begin
                            active_next   = 1'b1;
                            released_next = 1'b0;
                            pos_next      = start_pos;
                            timer_next    = '0;
                            rate_next     = ONE_SPEED;
                            state_next    = ST_READ;
                        end
                        FUNC_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Check the bound, then fetch the entry at the current position
            ST_READ: begin
                if (steps_reg == STEP_W'(MAX_STEPS)) begin
                    overrun_next = 1'b1;
                    run_next     = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    steps_next = steps_reg + 1'b1;
                    mem_req.re = 1'b1;
                    state_next = ST_EVAL;
                end
            end

            // Decode control entries, start the duration * rate product
            ST_EVAL: begin
                if (ent_dur == '0 && ent_code == CODE_LOOP) begin
                    pos_next   = start_pos;
                    state_next = ST_READ;
                end else if (ent_dur == '0 && ent_code == CODE_RELEASE) begin
                    active_next   = 1'b0;
                    released_next = 1'b1;
                    run_next      = 1'b0;
                    state_next    = ST_DONE;
                end else if (ent_dur == '0 && ent_code == CODE_HOLD) begin
                    run_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    prod_next  = ent_dur * rate_reg;
                    state_next = ST_ACCUM;
                end
            end

            // Add into the fraction; a whole tick or more selects the frame
            ST_ACCUM: begin
                frac_next = sum[FRAC_W-1:0];
                if (sum[SUM_W-1:FRAC_W] == '0) begin
                    pos_next   = pos_inc;
                    state_next = ST_READ;
                end else begin
                    timer_next   = sum[FRAC_W+TIMER_W-1:FRAC_W];
                    frame_next   = ent_code;
                    changed_next = 1'b1;
                    run_next     = 1'b1;
                    state_next   = ST_DONE;
                end
            end

            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and player state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            timer_reg    <= '0;
            frac_reg     <= '0;
            frame_reg    <= '0;
            active_reg   <= 1'b0;
            released_reg <= 1'b0;
            steps_reg    <= '0;
            run_reg      <= 1'b0;
            changed_reg  <= 1'b0;
            overrun_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            timer_reg    <= timer_next;
            frac_reg     <= frac_next;
            frame_reg    <= frame_next;
            active_reg   <= active_next;
            released_reg <= released_next;
            steps_reg    <= steps_next;
            run_reg      <= run_next;
            changed_reg  <= changed_next;
            overrun_reg  <= overrun_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rate_reg <= rate_next;
        prod_reg <= prod_next;
    end

endmodule

[design/sprite_animation_script_player.sv]
// Sprite animation script player. Each input transaction is a tick, a script
// entry write, a restart or a no-op, and each gives exactly one result. A
// write, a no-op, a tick on an idle or frozen player, and a tick whose frame
// timer has not run out go straight from acceptance to the result, with no
// walk. A walk through the script takes each entry it reads through READ
// (address), EVAL (registered store data with the duration * speed product)
// and ACCUM (accumulate); a loop, hold or release entry goes no further than
// EVAL. A walk reads at most 512 entries, after which the step bound check in
// READ ends it with step_overrun set. The script memory has a single
// registered read port, and the product is registered. The next transaction
// is accepted as soon as the result is in the output register; a write is
// taken only between walks, so reads and writes of the store never overlap.
module sprite_animation_script_player
    import sasp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // entry_index, entry_duration, entry_code, zero pad
    input  logic [1:0]  s_tuser,  // func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // running, frame_number, frame_changed, released,
                                  // step_overrun, zero pad
);

    cfg_t               cfg_reg;
    mem_req_t           mem_req;
    logic [ENTRY_W-1:0] mem_rdata;
    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               m_tvalid_reg;
    result_t            m_res_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed          <= ONE_SPEED;
            cfg_reg.start_position <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SPEED: cfg_reg.speed          <= cfg_wdata;
                CFG_START: cfg_reg.start_position <= cfg_wdata[START_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sasp_script_ram u_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    sasp_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_index    (s_tdata[5:0]),
        .in_duration (s_tdata[21:6]),
        .in_code     (s_tdata[37:22]),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000,
                       m_res_reg.step_overrun,
                       m_res_reg.released,
                       m_res_reg.frame_changed,
                       m_res_reg.frame_number,
                       m_res_reg.running};

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import sasp_pkg::*;

    // Run limit: every transaction taken as a worst-case 512-entry walk with random
    // gaps on both sides, several times over.
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_CMDS = 830;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] idx;
        logic [DUR_W-1:0]   dur;
        logic [CODE_W-1:0]  code;
    } script_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = CFG_SPEED;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // entry_index, entry_duration, entry_code, zero pad
    logic [1:0]  s_tuser = FUNC_NOP;  // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // running, frame_number, frame_changed, released,
                                 // step_overrun, zero pad

    sprite_animation_script_player dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Player state mirror
    logic [ENTRY_W-1:0] script_mem [SCRIPT_DEPTH];
    logic [POS_W-1:0]   play_pos = '0;
    logic [TIMER_W-1:0] frame_timer = '0;
    logic [FRAC_W-1:0]  frac_acc = '0;
    logic [CODE_W-1:0]  shown_frame = '0;
    logic               playing = 1'b0;
    logic               freed = 1'b0;
    logic [SPEED_W-1:0] cfg_speed = ONE_SPEED;
    logic [START_W-1:0] cfg_start = '0;

    script_cmd_t cmd_backlog[$];
    result_t     frames_due[$];
    int          cmds_queued = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    // Driver and receiver bookkeeping
    script_cmd_t tx_cmd;
    bit          tx_busy = 1'b0;
    bit          tx_quiet = 1'b0;
    int          tx_wait = 0;
    bit          rx_quiet = 1'b0;
    int          rx_wait = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    // Walk the script at the given rate until a frame is picked, the script ends,
    // or the step bound is hit. Returns the running flag.
    function automatic logic walk_script(input logic [SPEED_W-1:0] rate,
                                         output logic changed, output logic overrun);
        int                steps;
        logic [DUR_W-1:0]  dur;
        logic [CODE_W-1:0] code;
        logic [63:0]       sum;
        steps = 0;
        changed = 1'b0;
        overrun = 1'b0;
        if (frame_timer != '0) begin
            frame_timer = frame_timer - 1'b1;
            if (frame_timer != '0)
                return 1'b1;
            play_pos = play_pos + 1'b1;
        end
        while (1'b1) begin
            if (steps >= MAX_STEPS) begin
                overrun = 1'b1;
                return 1'b1;
            end
            steps++;
            {dur, code} = script_mem[play_pos];
            if (dur == '0) begin
                if (code == CODE_LOOP) begin
                    play_pos = POS_W'(cfg_start);
                    continue;
                end
                if (code == CODE_RELEASE) begin
                    playing = 1'b0;
                    freed = 1'b1;
                    return 1'b0;
                end
                if (code == CODE_HOLD)
                    return 1'b0;
            end
            sum = 64'(frac_acc) + 64'(dur) * 64'(rate);
            // not enough for a whole tick yet: bank the fraction and move on
            if (sum < 64'(ONE_SPEED)) begin
                frac_acc = sum[7:0];
                play_pos = play_pos + 1'b1;
                continue;
            end
            frame_timer = sum[31:8];
            frac_acc = sum[7:0];
            shown_frame = code;
            changed = 1'b1;
            return 1'b1;
        end
        return 1'b1;
    endfunction

    // Apply one command to the mirror and return the frame report it causes
    function automatic result_t play_step(input script_cmd_t cmd);
        result_t r;
        logic    ch;
        logic    ov;
        ch = 1'b0;
        ov = 1'b0;
        r.running = playing;
        case (cmd.func)
            FUNC_TICK: begin
                if (!playing)
                    r.running = 1'b0;
                else if (cfg_speed == '0)
                    r.running = 1'b1;
                else
                    r.running = walk_script(cfg_speed, ch, ov);
            end
            FUNC_WRITE: begin
                script_mem[cmd.idx] = {cmd.dur, cmd.code};
            end
            FUNC_RESTART: begin
                playing = 1'b1;
                freed = 1'b0;
                play_pos = POS_W'(cfg_start);
                frame_timer = '0;
                r.running = walk_script(ONE_SPEED, ch, ov);
            end
            default: ;
        endcase
        r.frame_number = shown_frame;
        r.frame_changed = ch;
        r.released = freed;
        r.step_overrun = ov;
        return r;
    endfunction

    task automatic push_cmd(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] idx,
                            input logic [DUR_W-1:0] dur, input logic [CODE_W-1:0] code);
        script_cmd_t c;
        c.func = func;
        c.idx = idx;
        c.dur = dur;
        c.code = code;
        cmd_backlog.push_back(c);
        if (func != FUNC_NOP)
            cmds_queued++;
    endtask

    task automatic put_entry(input logic [INDEX_W-1:0] idx, input logic [DUR_W-1:0] dur,
                             input logic [CODE_W-1:0] code);
        push_cmd(FUNC_WRITE, idx, dur, code);
    endtask

    // Hold the sender until every queued command has its report back
    task automatic drain_results();
        while (cmd_backlog.size() != 0 || tx_busy || frames_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write, only with the player idle
    task automatic set_reg(input logic addr, input logic [15:0] value);
        drain_results();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        if (addr == CFG_SPEED)
            cfg_speed = value;
        else
            cfg_start = value[START_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [CODE_W-1:0] want,
                               input logic [CODE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Input driver: one transaction per command, random gap after each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_busy = 1'b0;
            tx_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                frames_due.push_back(play_step(tx_cmd));
                tx_busy = 1'b0;
                tx_wait = tx_quiet ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 31) == 0)
                    tx_quiet = !tx_quiet;
            end
            if (!tx_busy) begin
                if (tx_wait > 0)
                    tx_wait--;
                else if (cmd_backlog.size() != 0) begin
                    tx_cmd = cmd_backlog.pop_front();
                    tx_busy = 1'b1;
                    s_tdata <= {2'b00, tx_cmd.code, tx_cmd.dur, tx_cmd.idx};
                    s_tuser <= tx_cmd.func;
                end
            end
            s_tvalid <= tx_busy;
        end
    end

    // Result monitor: compare each report with the oldest prediction
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("running", CODE_W'(want.running), CODE_W'(m_tdata[0]));
                    check_field("frame_number", want.frame_number, m_tdata[16:1]);
                    check_field("frame_changed", CODE_W'(want.frame_changed),
                                CODE_W'(m_tdata[17]));
                    check_field("released", CODE_W'(want.released), CODE_W'(m_tdata[18]));
                    check_field("step_overrun", CODE_W'(want.step_overrun),
                                CODE_W'(m_tdata[19]));
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 31) == 0)
                    rx_quiet = !rx_quiet;
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int          seg;
        int          base;
        int          len;
        int          nticks;
        int          pick;
        logic [15:0] spd;
        for (int i = 0; i < SCRIPT_DEPTH; i++)
            script_mem[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        set_reg(CFG_SPEED, ONE_SPEED);
        set_reg(CFG_START, 16'd0);

        // Fill the whole store so no walk reads an unwritten entry
        for (int i = 0; i < SCRIPT_DEPTH - 1; i++)
            put_entry(INDEX_W'(i), DUR_W'(1 + i % 3), CODE_W'(16 + i));
        put_entry(INDEX_W'(SCRIPT_DEPTH - 1), '0, CODE_LOOP);

        // Directed: idle tick, no-op, skip entry, extreme duration
        push_cmd(FUNC_TICK, '0, '0, '0);
        push_cmd(FUNC_NOP, 6'h3F, 16'hFFFF, 16'hFFFF);
        put_entry(6'd0, 16'd2, 16'h1234);
        put_entry(6'd1, 16'd0, 16'h0007);
        put_entry(6'd2, 16'hFFFF, 16'hFFFF);
        push_cmd(FUNC_RESTART, '0, '0, '0);
        push_cmd(FUNC_TICK, '0, '0, '0);
        push_cmd(FUNC_TICK, '0, '0, '0);

        // Frozen playback
        set_reg(CFG_SPEED, 16'd0);
        push_cmd(FUNC_TICK, '0, '0, '0);

        // Endless loop on the last entry: walk hits the step bound twice
        set_reg(CFG_SPEED, 16'd1);
        set_reg(CFG_START, 16'd63);
        push_cmd(FUNC_RESTART, '0, '0, '0);
        push_cmd(FUNC_TICK, '0, '0, '0);

        // Release at end of script, then a tick on the freed player
        set_reg(CFG_START, 16'd5);
        put_entry(6'd5, 16'd1, 16'hAAAA);
        put_entry(6'd6, 16'd0, CODE_RELEASE);
        push_cmd(FUNC_RESTART, '0, '0, '0);
        push_cmd(FUNC_TICK, '0, '0, '0);
        push_cmd(FUNC_TICK, '0, '0, '0);

        // Hold entry keeps the player parked
        put_entry(6'd7, 16'd0, CODE_HOLD);
        set_reg(CFG_START, 16'd7);
        push_cmd(FUNC_RESTART, '0, '0, '0);
        push_cmd(FUNC_TICK, '0, '0, '0);

        // Top speed against the longest duration
        set_reg(CFG_SPEED, 16'hFFFF);
        set_reg(CFG_START, 16'd0);
        push_cmd(FUNC_RESTART, '0, '0, '0);
        push_cmd(FUNC_TICK, '0, '0, '0);
        push_cmd(FUNC_TICK, '0, '0, '0);

        // Random scripts: write a short script, restart, tick through it with some noise
        cmds_queued = 0;
        seg = 0;
        while (cmds_queued < RANDOM_CMDS) begin
            if ($urandom_range(0, 3) == 0 || seg == 0) begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0: spd = 16'd0;
                    1: spd = 16'd1;
                    2: spd = 16'hFFFF;
                    3: spd = ONE_SPEED;
                    default: spd = 16'($urandom_range(16, 768));
                endcase
                set_reg(CFG_SPEED, spd);
            end
            base = $urandom_range(0, SCRIPT_DEPTH - 1);
            set_reg(CFG_START, 16'(base));
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    put_entry(INDEX_W'(base + k), '0, 16'($urandom));
                else if (pick == 1)
                    put_entry(INDEX_W'(base + k), 16'($urandom), 16'($urandom));
                else
                    put_entry(INDEX_W'(base + k), 16'($urandom_range(1, 6)), 16'($urandom));
            end
            pick = $urandom_range(0, 2);
            put_entry(INDEX_W'(base + len), '0,
                      (pick == 0) ? CODE_HOLD : (pick == 1) ? CODE_RELEASE : CODE_LOOP);
            // one segment runs against a long receiver hold-off
            if (seg == 2)
                hold_req = 1'b1;
            push_cmd(FUNC_RESTART, '0, '0, '0);
            nticks = $urandom_range(4, 40);
            for (int k = 0; k < nticks; k++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    put_entry(6'($urandom), 16'($urandom), 16'($urandom));
                else if (pick == 1)
                    push_cmd(FUNC_NOP, 6'($urandom), 16'($urandom), 16'($urandom));
                else if (pick == 2)
                    push_cmd(FUNC_RESTART, 6'($urandom), 16'($urandom), 16'($urandom));
                else
                    push_cmd(FUNC_TICK, 6'($urandom), 16'($urandom), 16'($urandom));
            end
            seg++;
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
